@@ sv/lsd_pkg.sv @@
// shared types and constants of the scan packet decoder
`default_nettype none

package lsd_pkg;

    localparam int POINTS_DEF   = 12;
    localparam int BYTES_DEF    = 47;
    localparam int BYTES_MAX    = 59;
    localparam int STORE_IDX_W  = $clog2(BYTES_MAX);
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] HEADER_BYTE = 8'h54;
    localparam logic [7:0] LENGTH_BYTE = 8'h2C;

    localparam logic signed [19:0] FULL_TURN = 20'sd36000;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_DISTANCE = 2'd0;
    localparam logic [1:0] REG_MAX_DISTANCE = 2'd1;
    localparam logic [1:0] REG_MIN_QUALITY  = 2'd2;
    localparam logic [1:0] REG_ANGLE_OFFSET = 2'd3;

    typedef struct packed {
        logic [15:0] min_distance;
        logic [15:0] max_distance;
        logic [7:0]  min_quality;
        logic [15:0] angle_offset;
    } cfg_t;

    // packet buffer handle: one of two banks
    typedef struct packed {
        logic valid;
        logic bank;
    } pkt_cmd_t;

    typedef struct packed {
        logic                   bank;
        logic [STORE_IDX_W-1:0] idx;
    } rd_req_t;

endpackage

`default_nettype wire

@@ sv/lsd_ifs.sv @@
// item channels of the scan packet decoder
`default_nettype none

interface lsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsd_point_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_angle;
    logic [15:0] point_distance;
    logic [7:0]  point_confidence;
    logic [3:0]  point_index;
    logic        in_range;
    logic [15:0] rotation_speed;
    logic [15:0] packet_time;
    logic        last_point;

    modport source (
        output valid, input ready,
        output point_angle, output point_distance, output point_confidence,
        output point_index, output in_range, output rotation_speed,
        output packet_time, output last_point
    );
    modport sink (
        input valid, output ready,
        input point_angle, input point_distance, input point_confidence,
        input point_index, input in_range, input rotation_speed,
        input packet_time, input last_point
    );
endinterface

`default_nettype wire

@@ sv/lsd_front.sv @@
// byte collector: header hunt, packet framing and double-banked packet buffer
`default_nettype none

module lsd_front
    import lsd_pkg::*;
#(
    parameter int PACKET_BYTES = BYTES_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    lsd_byte_if.sink      rx,
    output pkt_cmd_t      push,
    input  wire pkt_cmd_t done,
    input  wire rd_req_t  rd_req,
    output logic [7:0]    rd_data
);

    localparam logic [STORE_IDX_W-1:0] LAST_IDX = STORE_IDX_W'(PACKET_BYTES - 1);
    localparam logic [STORE_IDX_W-1:0] LEN_IDX  = STORE_IDX_W'(1);

    logic [STORE_IDX_W-1:0] count_reg, count_next;
    logic                   bank_reg, bank_next;
    logic [1:0]             busy_reg, busy_next;
    logic                   accept;
    logic                   wr_en;

    logic [7:0] store_mem [0:2**(STORE_IDX_W+1)-1];

    assign rx.ready = ~busy_reg[bank_reg];
    assign accept   = rx.valid & rx.ready;

    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        wr_en      = 1'b0;
        push       = '0;
        if (done.valid)
        begin
            busy_next[done.bank] = 1'b0;
        end
        if (accept)
        begin
            if (count_reg == '0)
            begin
                if (rx.rx_byte == HEADER_BYTE)
                begin
                    wr_en      = 1'b1;
                    count_next = LEN_IDX;
                end
            end
            else
            begin
                wr_en = 1'b1;
                if (count_reg == LEN_IDX && rx.rx_byte != LENGTH_BYTE)
                begin
                    count_next = '0;
                end
                else if (count_reg == LAST_IDX)
                begin
                    // packet complete: hand the bank to the back end
                    count_next          = '0;
                    push.valid          = 1'b1;
                    push.bank           = bank_reg;
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                end
                else
                begin
                    count_next = count_reg + STORE_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[{bank_reg, count_reg}] <= rx.rx_byte;
        end
        rd_data <= store_mem[{rd_req.bank, rd_req.idx}];
    end

endmodule

`default_nettype wire

@@ sv/lsd_queue.sv @@
// short queue of finished packet banks between front and back end
`default_nettype none

module lsd_queue
    import lsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pkt_cmd_t push,
    input  wire logic     pop,
    output pkt_cmd_t      head
);

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    logic            slot_reg [0:QUEUE_DEPTH-1];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]   fill_reg, fill_next;
    logic            do_pop;

    assign head.valid = (fill_reg != '0);
    assign head.bank  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop & head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + QP_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QP_W'(1);
        end
        if (push.valid && !do_pop)
        begin
            fill_next = fill_reg + (QP_W+1)'(1);
        end
        else if (!push.valid && do_pop)
        begin
            fill_next = fill_reg - (QP_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.bank;
        end
    end

endmodule

`default_nettype wire

@@ sv/lsd_back.sv @@
// point sequencer: header fetch, angle step divider and point emission
`default_nettype none

module lsd_back
    import lsd_pkg::*;
#(
    parameter int POINTS_PER_PACKET = POINTS_DEF,
    parameter int PACKET_BYTES      = BYTES_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire pkt_cmd_t head,
    output logic          pop,
    output pkt_cmd_t      done,
    output rd_req_t       rd_req,
    input  wire logic [7:0] rd_data,
    lsd_point_if.source   points
);

    localparam int PT_W     = $clog2(POINTS_PER_PACKET);
    localparam int IW       = STORE_IDX_W;
    localparam int RECIP_SH = 20;

    // ceil(2^20 / (points - 1)), exact for every 16-bit span and divisor up to 15
    localparam logic [RECIP_SH:0] RECIP =
        (RECIP_SH+1)'(((1 << RECIP_SH) + POINTS_PER_PACKET - 2) / (POINTS_PER_PACKET - 1));
    localparam logic [PT_W-1:0] LAST_PT  = PT_W'(POINTS_PER_PACKET - 1);
    localparam logic [IW-1:0]   STORE_SZ = IW'(PACKET_BYTES);
    localparam logic [IW-1:0]   FIRST_PT = IW'(6);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_HDR    = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_PFETCH = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    // fetch tags, the header ones in fetch order
    localparam logic [3:0] TAG_SPD_L = 4'd0;
    localparam logic [3:0] TAG_SPD_H = 4'd1;
    localparam logic [3:0] TAG_STA_L = 4'd2;
    localparam logic [3:0] TAG_STA_H = 4'd3;
    localparam logic [3:0] TAG_END_L = 4'd4;
    localparam logic [3:0] TAG_END_H = 4'd5;
    localparam logic [3:0] TAG_TIM_L = 4'd6;
    localparam logic [3:0] TAG_TIM_H = 4'd7;
    localparam logic [3:0] TAG_DST_L = 4'd8;
    localparam logic [3:0] TAG_DST_H = 4'd9;
    localparam logic [3:0] TAG_CONF  = 4'd10;
    localparam logic [3:0] HDR_FETCHES = 4'd8;
    localparam logic [3:0] PT_FETCHES  = 4'd3;

    logic [2:0]      state_reg, state_next;
    logic            bank_reg, bank_next;
    logic [3:0]      fetch_k_reg, fetch_k_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic [3:0]      rd_tag_reg, rd_tag_next;
    logic            rd_go_reg, rd_go_next;
    logic [3:0]      dat_tag_reg;
    logic            dat_go_reg;
    logic            dat_zero_reg;

    logic [15:0]     speed_reg, start_reg, end_reg, stamp_reg, dist_reg;
    logic [7:0]      conf_reg;

    logic [15:0]     quo_reg, quo_next;
    logic            neg_reg, neg_next;
    logic signed [19:0] acc_reg, acc_next;
    logic [PT_W-1:0] pt_reg, pt_next;
    logic [IW-1:0]   pbase_reg, pbase_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_load;
    logic [15:0]     angle_reg, odist_reg, ospeed_reg, ostamp_reg;
    logic [7:0]      oconf_reg;
    logic [3:0]      oindex_reg;
    logic            orange_reg, olast_reg;

    logic [7:0]         cap_byte;
    logic [IW-1:0]      hdr_idx;
    logic signed [17:0] diff;
    logic [17:0]        diff_mag;
    logic [RECIP_SH+16:0] quo_prod;
    logic signed [19:0] step;
    logic signed [19:0] raw_red;
    logic signed [19:0] ang;
    logic [15:0]        ang_sat;
    logic               in_range_w;

    assign cap_byte = dat_zero_reg ? 8'h00 : rd_data;

    assign rd_req.bank = bank_reg;
    assign rd_req.idx  = rd_idx_reg;

    always_comb
    begin
        case (fetch_k_reg)
            TAG_SPD_L: hdr_idx = IW'(2);
            TAG_SPD_H: hdr_idx = IW'(3);
            TAG_STA_L: hdr_idx = IW'(4);
            TAG_STA_H: hdr_idx = IW'(5);
            TAG_END_L: hdr_idx = IW'(PACKET_BYTES - 5);
            TAG_END_H: hdr_idx = IW'(PACKET_BYTES - 4);
            TAG_TIM_L: hdr_idx = IW'(PACKET_BYTES - 3);
            default:   hdr_idx = IW'(PACKET_BYTES - 2);
        endcase
    end

    // angle span of the packet, wrapped when the end angle is not above the start
    always_comb
    begin
        if (end_reg > start_reg)
        begin
            diff = $signed({2'b00, end_reg}) - $signed({2'b00, start_reg});
        end
        else
        begin
            diff = $signed({2'b00, end_reg}) + 18'sd36000 - $signed({2'b00, start_reg});
        end
        diff_mag = diff[17] ? 18'(-diff) : 18'(diff);
    end

    assign quo_prod = (RECIP_SH+17)'(quo_reg) * (RECIP_SH+17)'(RECIP);
    assign step     = neg_reg ? -$signed({4'b0000, quo_reg}) : $signed({4'b0000, quo_reg});

    always_comb
    begin
        raw_red = (acc_reg > FULL_TURN) ? (acc_reg - FULL_TURN) : acc_reg;
        ang     = FULL_TURN - raw_red;
        if (ang < 20'sd0)
        begin
            ang_sat = 16'd0;
        end
        else if (ang > FULL_TURN)
        begin
            ang_sat = 16'(FULL_TURN);
        end
        else
        begin
            ang_sat = ang[15:0];
        end
    end

    assign in_range_w = (dist_reg >= cfg.min_distance) && (dist_reg <= cfg.max_distance)
                        && (conf_reg >= cfg.min_quality);

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        fetch_k_next   = fetch_k_reg;
        rd_idx_next    = rd_idx_reg;
        rd_tag_next    = rd_tag_reg;
        rd_go_next     = 1'b0;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        pt_next        = pt_reg;
        pbase_next     = pbase_reg;
        out_valid_next = out_valid_reg & ~points.ready;
        out_load       = 1'b0;
        pop            = 1'b0;
        done           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop          = 1'b1;
                    bank_next    = head.bank;
                    fetch_k_next = '0;
                    state_next   = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (fetch_k_reg < HDR_FETCHES)
                begin
                    rd_go_next   = 1'b1;
                    rd_idx_next  = hdr_idx;
                    rd_tag_next  = fetch_k_reg;
                    fetch_k_next = fetch_k_reg + 4'd1;
                end
                if (dat_go_reg && dat_tag_reg == TAG_TIM_H)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                quo_next     = diff_mag[15:0];
                neg_next     = diff[17];
                acc_next     = $signed({4'b0000, start_reg})
                               + $signed({4'b0000, cfg.angle_offset});
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // step magnitude as a multiply by the reciprocal of points - 1
                quo_next     = quo_prod[RECIP_SH+15:RECIP_SH];
                pt_next      = '0;
                pbase_next   = FIRST_PT;
                fetch_k_next = '0;
                state_next   = ST_PFETCH;
            end
            ST_PFETCH:
            begin
                if (fetch_k_reg < PT_FETCHES)
                begin
                    rd_go_next   = 1'b1;
                    rd_idx_next  = pbase_reg + IW'(fetch_k_reg);
                    rd_tag_next  = TAG_DST_L + fetch_k_reg;
                    fetch_k_next = fetch_k_reg + 4'd1;
                end
                if (dat_go_reg && dat_tag_reg == TAG_CONF)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || points.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    acc_next       = acc_reg + step;
                    pt_next        = pt_reg + PT_W'(1);
                    pbase_next     = pbase_reg + IW'(3);
                    fetch_k_next   = '0;
                    if (pt_reg == LAST_PT)
                    begin
                        done.valid = 1'b1;
                        done.bank  = bank_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PFETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fetch_k_reg   <= '0;
            rd_go_reg     <= 1'b0;
            dat_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_k_reg   <= fetch_k_next;
            rd_go_reg     <= rd_go_next;
            dat_go_reg    <= rd_go_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg     <= bank_next;
        rd_idx_reg   <= rd_idx_next;
        rd_tag_reg   <= rd_tag_next;
        dat_tag_reg  <= rd_tag_reg;
        // bytes past the end of the packet read as zero
        dat_zero_reg <= (rd_idx_reg >= STORE_SZ);
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        pt_reg       <= pt_next;
        pbase_reg    <= pbase_next;
        if (dat_go_reg)
        begin
            case (dat_tag_reg)
                TAG_SPD_L: speed_reg[7:0]  <= cap_byte;
                TAG_SPD_H: speed_reg[15:8] <= cap_byte;
                TAG_STA_L: start_reg[7:0]  <= cap_byte;
                TAG_STA_H: start_reg[15:8] <= cap_byte;
                TAG_END_L: end_reg[7:0]    <= cap_byte;
                TAG_END_H: end_reg[15:8]   <= cap_byte;
                TAG_TIM_L: stamp_reg[7:0]  <= cap_byte;
                TAG_TIM_H: stamp_reg[15:8] <= cap_byte;
                TAG_DST_L: dist_reg[7:0]   <= cap_byte;
                TAG_DST_H: dist_reg[15:8]  <= cap_byte;
                TAG_CONF:  conf_reg        <= cap_byte;
                default:   conf_reg        <= conf_reg;
            endcase
        end
        if (out_load)
        begin
            angle_reg  <= ang_sat;
            odist_reg  <= dist_reg;
            oconf_reg  <= conf_reg;
            oindex_reg <= 4'(pt_reg);
            orange_reg <= in_range_w;
            ospeed_reg <= speed_reg;
            ostamp_reg <= stamp_reg;
            olast_reg  <= (pt_reg == LAST_PT);
        end
    end

    assign points.valid            = out_valid_reg;
    assign points.point_angle      = angle_reg;
    assign points.point_distance   = odist_reg;
    assign points.point_confidence = oconf_reg;
    assign points.point_index      = oindex_reg;
    assign points.in_range         = orange_reg;
    assign points.rotation_speed   = ospeed_reg;
    assign points.packet_time      = ostamp_reg;
    assign points.last_point       = olast_reg;

endmodule

`default_nettype wire

@@ sv/lidar_scan_packet_decoder.sv @@
// top level of the scan packet decoder with its configuration registers
//
// Received bytes enter on rx, one per item, and are taken in one cycle each as long as one
// of the two packet buffer banks is free; bytes are dropped until the header byte 0x54
// appears, and a second byte other than 0x2C sends the decoder back to hunting. When the
// last byte of a packet arrives, the bank is queued for the point sequencer, which reads
// the header fields, gets the angle step from a reciprocal multiply, and then fetches three
// buffer bytes per point before it emits that point; emission waits while points is stalled.
// Input stalls only while both banks hold packets whose points are not all emitted yet.
// The packet checksum is not checked.
`default_nettype none

module lidar_scan_packet_decoder
    import lsd_pkg::*;
#(
    parameter int POINTS_PER_PACKET = POINTS_DEF,
    parameter int PACKET_BYTES      = BYTES_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    lsd_byte_if.sink         rx,
    lsd_point_if.source      points,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    pkt_cmd_t push;
    pkt_cmd_t head;
    pkt_cmd_t done;
    logic     pop;
    rd_req_t  rd_req;
    logic [7:0] rd_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_DISTANCE: cfg_next.min_distance = cfg_data;
                REG_MAX_DISTANCE: cfg_next.max_distance = cfg_data;
                REG_MIN_QUALITY:  cfg_next.min_quality  = cfg_data[7:0];
                REG_ANGLE_OFFSET: cfg_next.angle_offset = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_distance <= 16'd50;
            cfg_reg.max_distance <= 16'd2500;
            cfg_reg.min_quality  <= 8'd200;
            cfg_reg.angle_offset <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsd_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .push    (push),
        .done    (done),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    lsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head)
    );

    lsd_back #(
        .POINTS_PER_PACKET (POINTS_PER_PACKET),
        .PACKET_BYTES      (PACKET_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .pop     (pop),
        .done    (done),
        .rd_req  (rd_req),
        .rd_data (rd_data),
        .points  (points)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench of the scan packet decoder: byte stream in, predicted points checked out
`timescale 1ns / 100ps

module tb
    import lsd_pkg::*;
();

    localparam int     SETTLE_CYCLES = 200;
    localparam int     PAYLOAD_GOAL  = 160;
    localparam int     PHASE_BYTES   = 40;
    localparam longint TURN          = longint'(FULL_TURN);

    // boundary points around the reset window: 50..2500 mm, quality 200
    localparam logic [15:0] LIMIT_DIST [12] =
        '{0, 49, 50, 50, 2500, 2500, 2501, 65535, 1000, 1000, 50, 2500};
    localparam logic [7:0]  LIMIT_CONF [12] =
        '{255, 255, 255, 199, 200, 255, 255, 255, 0, 200, 200, 199};

    typedef struct packed {
        logic [15:0] point_angle;
        logic [15:0] point_distance;
        logic [7:0]  point_confidence;
        logic [3:0]  point_index;
        logic        in_range;
        logic [15:0] rotation_speed;
        logic [15:0] packet_time;
        logic        last_point;
    } point_t;

    class point_scoreboard;
        int         min_dist;
        int         max_dist;
        int         min_qual;
        int         offset;
        int         fill;           // bytes of the current packet, 0 while hunting
        logic [7:0] store [BYTES_DEF];
        point_t     pending_points [$];
        int         errors;

        function new();
            min_dist = 50;
            max_dist = 2500;
            min_qual = 200;
            offset   = 0;
            fill     = 0;
            errors   = 0;
            foreach (store[i])
                store[i] = 8'h00;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_MIN_DISTANCE: min_dist = int'(data);
                REG_MAX_DISTANCE: max_dist = int'(data);
                REG_MIN_QUALITY:  min_qual = int'(data[7:0]);
                REG_ANGLE_OFFSET: offset   = int'(data);
                default: ;
            endcase
        endfunction

        function longint word_at(int i);
            return longint'({store[i + 1], store[i]});
        endfunction

        function void decode_points();
            longint start_ang;
            longint stop_ang;
            longint angle_step;
            longint raw;
            longint ang;
            int     base;
            point_t p;
            start_ang = word_at(4);
            stop_ang  = word_at(BYTES_DEF - 5);
            if (stop_ang > start_ang)
                angle_step = (stop_ang - start_ang) / (POINTS_DEF - 1);
            else
                angle_step = (stop_ang + TURN - start_ang) / (POINTS_DEF - 1);
            for (int i = 0; i < POINTS_DEF; i++)
            begin
                raw = start_ang + longint'(i) * angle_step + longint'(offset);
                if (raw > TURN)
                    raw -= TURN;
                ang = TURN - raw;
                if (ang < 0)
                    ang = 0;
                if (ang > TURN)
                    ang = TURN;
                base = 6 + 3 * i;
                p.point_angle      = 16'(ang);
                p.point_distance   = {store[base + 1], store[base]};
                p.point_confidence = store[base + 2];
                p.point_index      = 4'(i);
                p.in_range         = int'(p.point_distance) >= min_dist &&
                                     int'(p.point_distance) <= max_dist &&
                                     int'(p.point_confidence) >= min_qual;
                p.rotation_speed   = 16'(word_at(2));
                p.packet_time      = 16'(word_at(BYTES_DEF - 3));
                p.last_point       = (i == POINTS_DEF - 1);
                pending_points = {pending_points, p};
            end
        endfunction

        // returns 1 when the byte belongs to a packet rather than being skipped
        function bit take_byte(logic [7:0] b);
            if (fill == 0)
            begin
                if (b == HEADER_BYTE)
                begin
                    store[0] = b;
                    fill = 1;
                    return 1'b1;
                end
                return 1'b0;
            end
            store[fill] = b;
            fill++;
            if (store[1] != LENGTH_BYTE)
                fill = 0;
            else if (fill == BYTES_DEF)
            begin
                fill = 0;
                decode_points();
            end
            return 1'b1;
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (pending_points.size() == 0)
            begin
                $display("%0t: point expected none actual index %0d angle %0d",
                         $time, got.point_index, got.point_angle);
                errors++;
                return;
            end
            want = pending_points.pop_front();
            compare("point_angle", want.point_angle, got.point_angle);
            compare("point_distance", want.point_distance, got.point_distance);
            compare("point_confidence", 16'(want.point_confidence), 16'(got.point_confidence));
            compare("point_index", 16'(want.point_index), 16'(got.point_index));
            compare("in_range", 16'(want.in_range), 16'(got.in_range));
            compare("rotation_speed", want.rotation_speed, got.rotation_speed);
            compare("packet_time", want.packet_time, got.packet_time);
            compare("last_point", 16'(want.last_point), 16'(got.last_point));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        sink_ready = 1'b0;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          payload_bytes = 0;
    logic [7:0]  frame [BYTES_DEF];
    point_scoreboard sb;

    lsd_byte_if  rx_ch ();
    lsd_point_if pt_ch ();

    assign pt_ch.ready = sink_ready;

    lidar_scan_packet_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .points    (pt_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        sink_ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin : point_check
        point_t got;
        if (rst_n && pt_ch.valid && pt_ch.ready)
        begin
            got.point_angle      = pt_ch.point_angle;
            got.point_distance   = pt_ch.point_distance;
            got.point_confidence = pt_ch.point_confidence;
            got.point_index      = pt_ch.point_index;
            got.in_range         = pt_ch.in_range;
            got.rotation_speed   = pt_ch.rotation_speed;
            got.packet_time      = pt_ch.packet_time;
            got.last_point       = pt_ch.last_point;
            sb.check_point(got);
        end
    end

    function automatic logic [15:0] angle_word();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(35999));
    endfunction

    function automatic void frame_point(int i, logic [15:0] pt_dist, logic [7:0] conf);
        {frame[7 + 3 * i], frame[6 + 3 * i]} = pt_dist;
        frame[8 + 3 * i] = conf;
    endfunction

    // fills a well-formed frame, points random with most distances near the window
    function automatic void frame_header(logic [15:0] speed, logic [15:0] start_ang,
                                         logic [15:0] stop_ang, logic [15:0] stamp);
        frame[0] = HEADER_BYTE;
        frame[1] = LENGTH_BYTE;
        {frame[3], frame[2]} = speed;
        {frame[5], frame[4]} = start_ang;
        {frame[BYTES_DEF - 4], frame[BYTES_DEF - 5]} = stop_ang;
        {frame[BYTES_DEF - 2], frame[BYTES_DEF - 3]} = stamp;
        frame[BYTES_DEF - 1] = 8'($urandom);
        for (int i = 0; i < POINTS_DEF; i++)
            frame_point(i, ($urandom_range(2) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(3000)),
                        8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        if (sb.take_byte(b))
            payload_bytes++;
    endtask

    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++)
            send_byte(frame[i]);
    endtask

    task automatic send_sequence();
        int         pick;
        logic [7:0] junk;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            frame_header(16'($urandom), angle_word(), angle_word(), 16'($urandom));
            send_frame(BYTES_DEF);
        end
        else if (pick < 88)
            repeat ($urandom_range(6, 1))
                send_byte(8'($urandom));
        else if (pick < 95)
        begin
            do
                junk = 8'($urandom);
            while (junk == LENGTH_BYTE);
            send_byte(HEADER_BYTE);
            send_byte(junk);
        end
        else
        begin
            // cut short: the next sequence runs on as the rest of this packet
            frame_header(16'($urandom), angle_word(), angle_word(), 16'($urandom));
            send_frame($urandom_range(BYTES_DEF - 1, 3));
        end
    endtask

    task automatic write_cfg(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] qual, input logic [15:0] off);
        logic [1:0]  regs [4];
        logic [15:0] vals [4];
        regs = '{REG_MIN_DISTANCE, REG_MAX_DISTANCE, REG_MIN_QUALITY, REG_ANGLE_OFFSET};
        vals = '{lo, hi, qual, off};
        for (int r = 0; r < 4; r++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            sb.set_reg(regs[r], vals[r]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // idle input, all points out, then room for a packet still in flight
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_start;
        sb = new();
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_MIN_DISTANCE;
        cfg_data      <= 16'h0000;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hunting noise, then broken headers (second header byte is also a bad length)
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(LENGTH_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(8'h00);
        send_byte(HEADER_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(LENGTH_BYTE);
        send_byte(HEADER_BYTE);
        send_byte(8'hFF);

        // zero fields, start equal to stop, in_range boundaries at reset settings
        frame_header(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < POINTS_DEF; i++)
            frame_point(i, LIMIT_DIST[i], LIMIT_CONF[i]);
        send_frame(BYTES_DEF);

        // all ones: raw angle far past a full turn, so that most points clamp at zero
        frame_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(BYTES_DEF);

        // stop angle wraps past zero
        frame_header(16'($urandom), 16'd35000, 16'd1000, 16'($urandom));
        send_frame(BYTES_DEF);
        wait_drained();

        payload_bytes = 0;
        phase = 1;
        while (payload_bytes < PAYLOAD_GOAL)
        begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            // upper bits of the quality write are junk and must be masked off
            case (phase)
                1: write_cfg(16'd0, 16'hFFFF, {8'($urandom), 8'd0}, 16'd35999);
                2: write_cfg(16'hFFFF, 16'd0, {8'($urandom), 8'd255}, 16'd0);
                3: write_cfg(16'hFFFF, 16'hFFFF, {8'($urandom), 8'd0}, 16'd18000);
                default: write_cfg(16'($urandom_range(1500)), 16'($urandom_range(65535, 1500)),
                                   16'($urandom), 16'($urandom_range(35999)));
            endcase
            phase_start = payload_bytes;
            while (payload_bytes - phase_start < PHASE_BYTES && payload_bytes < PAYLOAD_GOAL)
                send_sequence();
            wait_drained();
            phase++;
        end

        if (sb.errors == 0 && sb.pending_points.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin : watchdog
        #(10_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule
